// ===== rtl/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types and constants of the stream hash: round constants, initial
// hash values, controller command and status structures.
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int unsigned WordW = 32;

    localparam logic [7:0] PadByte = 8'h80;
    localparam logic [5:0] LenPos  = 6'd56;

    typedef logic [WordW-1:0] word_t;

    localparam word_t InitH [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};

    localparam word_t RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
        32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
        32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
        32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
        32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
        32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
        32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
        32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
        32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    // byte source selection for the block buffer write
    typedef enum logic [1:0] {
        BSEL_DATA = 2'd0,
        BSEL_PAD  = 2'd1,
        BSEL_ZERO = 2'd2,
        BSEL_LEN  = 2'd3
    } byte_sel_t;

    typedef struct packed {
        logic      wr_byte;
        byte_sel_t byte_sel;
        logic      round_start;
        logic      round_step;
        logic      hash_update;
        logic      block_done;
        logic      latch_total;
        logic      msg_reset;
        logic      out_load;
        logic      out_advance;
    } dp_cmd_t;

    typedef struct packed {
        logic [5:0] fill;
        logic       round_last;
        logic       out_last;
    } dp_status_t;

endpackage

// ===== rtl/sha_datapath.sv =====
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block buffer, message schedule, round unit, hash state, bit count and
// digest output register.
// ----------------------------------------------------------------------------
module sha_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  sha_pkg::dp_cmd_t    cmd,
    input  logic [7:0]          data_byte,
    output sha_pkg::dp_status_t status,
    output logic [31:0]         digest_word,
    output logic [2:0]          word_index,
    output logic                last_word
);

    logic [7:0]          buf_reg [64];
    logic [5:0]          fill_reg, fill_next;
    logic [63:0]         bits_reg;
    logic [63:0]         total_reg;
    sha_pkg::word_t      h_reg [8];
    sha_pkg::word_t      v_reg [8];
    sha_pkg::word_t      w_reg [16];
    logic [5:0]          rnd_reg;
    logic [2:0]          oidx_reg;
    sha_pkg::word_t      oword_reg;
    logic [7:0]          wbyte;
    logic [2:0]          lenk;
    sha_pkg::word_t      wt, wnew, s0, s1, t1, t2, ch, mj, a, e;

    assign lenk = fill_reg[2:0];

    always_comb begin
        case (cmd.byte_sel)
            sha_pkg::BSEL_DATA: wbyte = data_byte;
            sha_pkg::BSEL_PAD:  wbyte = sha_pkg::PadByte;
            sha_pkg::BSEL_ZERO: wbyte = 8'h00;
            sha_pkg::BSEL_LEN:  wbyte = total_reg[8*(7-lenk) +: 8];
            default:            wbyte = 8'h00;
        endcase
    end

    always_comb begin
        fill_next = fill_reg;
        if (cmd.wr_byte) begin
            fill_next = fill_reg + 6'd1;
        end
        if (cmd.msg_reset) begin
            fill_next = '0;
        end
    end

    // shift bytes in at the end; a full block leaves the first byte at index 0
    always_ff @(posedge aclk) begin
        if (cmd.wr_byte) begin
            for (int i = 0; i < 63; i++) begin
                buf_reg[i] <= buf_reg[i+1];
            end
            buf_reg[63] <= wbyte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            bits_reg <= '0;
        end else begin
            fill_reg <= fill_next;
            if (cmd.msg_reset) begin
                bits_reg <= '0;
            end else if (cmd.block_done) begin
                bits_reg <= bits_reg + 64'd512;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_total) begin
            total_reg <= bits_reg + {55'd0, fill_reg, 3'd0};
        end
    end

    // message schedule over a sliding window of 16 words
    assign s0   = {w_reg[1][6:0], w_reg[1][31:7]} ^ {w_reg[1][17:0], w_reg[1][31:18]}
                ^ (w_reg[1] >> 3);
    assign s1   = {w_reg[14][16:0], w_reg[14][31:17]}
                ^ {w_reg[14][18:0], w_reg[14][31:19]} ^ (w_reg[14] >> 10);
    assign wnew = s1 + w_reg[9] + s0 + w_reg[0];
    assign wt   = w_reg[0];

    assign a  = v_reg[0];
    assign e  = v_reg[4];
    assign ch = (e & v_reg[5]) ^ (~e & v_reg[6]);
    assign mj = (a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1 = v_reg[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
              + ch + sha_pkg::RoundK[rnd_reg] + wt;
    assign t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]}) + mj;

    always_ff @(posedge aclk) begin
        if (cmd.round_start) begin
            rnd_reg <= '0;
            for (int i = 0; i < 8; i++) begin
                v_reg[i] <= h_reg[i];
            end
            for (int i = 0; i < 16; i++) begin
                w_reg[i] <= {buf_reg[4*i], buf_reg[4*i+1], buf_reg[4*i+2], buf_reg[4*i+3]};
            end
        end else if (cmd.round_step) begin
            rnd_reg  <= rnd_reg + 6'd1;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
            for (int i = 0; i < 15; i++) begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= wnew;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) begin
                h_reg[i] <= sha_pkg::InitH[i];
            end
        end else if (cmd.msg_reset) begin
            for (int i = 0; i < 8; i++) begin
                h_reg[i] <= sha_pkg::InitH[i];
            end
        end else if (cmd.hash_update) begin
            for (int i = 0; i < 8; i++) begin
                h_reg[i] <= h_reg[i] + v_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            oidx_reg  <= '0;
            oword_reg <= h_reg[0];
        end else if (cmd.out_advance) begin
            oidx_reg  <= oidx_reg + 3'd1;
            oword_reg <= h_reg[oidx_reg + 3'd1];
        end
    end

    assign digest_word       = oword_reg;
    assign word_index        = oidx_reg;
    assign last_word         = (oidx_reg == 3'd7);
    assign status.fill       = fill_reg;
    assign status.round_last = (rnd_reg == 6'd63);
    assign status.out_last   = (oidx_reg == 3'd7);

endmodule

// ===== rtl/sha_ctrl.sv =====
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte intake, compression rounds, padding and digest output.
// ----------------------------------------------------------------------------
module sha_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                has_byte,
    input  logic                end_of_message,
    output logic                out_valid,
    input  logic                out_ready,
    input  sha_pkg::dp_status_t status,
    output sha_pkg::dp_cmd_t    cmd
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_LOAD  = 9'b000000010,
        ST_ROUND = 9'b000000100,
        ST_ADD   = 9'b000001000,
        ST_PAD   = 9'b000010000,
        ST_ZERO  = 9'b000100000,
        ST_LEN   = 9'b001000000,
        ST_OUT   = 9'b010000000,
        ST_CLEAR = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   fin_reg, fin_next;
    logic   lenblk_reg, lenblk_next;
    logic   pad_reg, pad_next;

    always_comb begin
        state_next  = state_reg;
        fin_next    = fin_reg;
        lenblk_next = lenblk_reg;
        pad_next    = pad_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.byte_sel = sha_pkg::BSEL_DATA;
                    cmd.wr_byte  = has_byte;
                    fin_next     = end_of_message;
                    lenblk_next  = 1'b0;
                    pad_next     = 1'b0;
                    if (has_byte && status.fill == 6'd63) begin
                        state_next = ST_LOAD;
                    end else if (end_of_message) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                cmd.latch_total = 1'b1;
                cmd.wr_byte     = 1'b1;
                cmd.byte_sel    = sha_pkg::BSEL_PAD;
                pad_next        = 1'b1;
                if (status.fill == 6'd63) begin
                    state_next = ST_LOAD;
                end else if (status.fill == sha_pkg::LenPos - 6'd1) begin
                    state_next = ST_LEN;
                end else begin
                    state_next = ST_ZERO;
                end
            end
            ST_ZERO: begin
                cmd.wr_byte  = 1'b1;
                cmd.byte_sel = sha_pkg::BSEL_ZERO;
                if (status.fill == 6'd63) begin
                    state_next = ST_LOAD;
                end else if (status.fill == sha_pkg::LenPos - 6'd1) begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN: begin
                cmd.wr_byte  = 1'b1;
                cmd.byte_sel = sha_pkg::BSEL_LEN;
                if (status.fill == 6'd63) begin
                    lenblk_next = 1'b1;
                    state_next  = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.round_start = 1'b1;
                state_next      = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.round_step = 1'b1;
                if (status.round_last) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                cmd.hash_update = 1'b1;
                cmd.block_done  = !pad_reg;
                if (lenblk_reg) begin
                    state_next = ST_CLEAR;
                end else if (pad_reg) begin
                    state_next = ST_ZERO;
                end else if (fin_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_CLEAR: begin
                cmd.out_load = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                out_valid = 1'b1;
                if (out_ready) begin
                    cmd.out_advance = 1'b1;
                    if (status.out_last) begin
                        cmd.msg_reset = 1'b1;
                        fin_next      = 1'b0;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            fin_reg    <= 1'b0;
            lenblk_reg <= 1'b0;
            pad_reg    <= 1'b0;
        end else begin
            state_reg  <= state_next;
            fin_reg    <= fin_next;
            lenblk_reg <= lenblk_next;
            pad_reg    <= pad_next;
        end
    end

endmodule

// ===== rtl/sha256_stream_hash_top.sv =====
// ----------------------------------------------------------------------------
// SHA-256 stream hash
// Bytes arrive one per transfer; on the end mark the digest leaves as eight
// word transfers, most significant first. The 64th byte of a block starts
// the one-round-per-cycle compression unit. The end mark writes padding and
// length bytes up to the end of the last block, compresses each padded block
// (one or two) and loads the output register before the output transfers.
// Input is held off during compression, padding and output.
// ----------------------------------------------------------------------------
module sha256_stream_hash_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // has_byte
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic        m_tlast    // last_word
);

    sha_pkg::dp_cmd_t    cmd;
    sha_pkg::dp_status_t status;
    logic [31:0]         digest_word;
    logic [2:0]          word_index;

    sha_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .has_byte       (s_tuser),
        .end_of_message (s_tlast),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .status         (status),
        .cmd            (cmd)
    );

    sha_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .data_byte   (s_tdata),
        .status      (status),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (m_tlast)
    );

    assign m_tdata = {5'd0, word_index, digest_word};

endmodule
